/* src/hts_pkg.sv */
// Shared constants for the heightmap triangle sampler: defaults, port field widths, request kinds, bank count.
package hts_pkg;

    // Default configuration of the height grid.
    localparam int GRID_DIM_DEF    = 256;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int HEIGHT_BITS_DEF = 16;

    // Fixed field widths of the stream channels.
    localparam int POS_W    = 16;
    localparam int HIN_W    = 16;
    localparam int HOUT_W   = 24;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    // Request kinds carried on s_tuser.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Number of parity banks the grid is split into.
    localparam int NUM_BANKS = 4;

endpackage

/* src/heightmap_triangle_sample.sv */
// Heightmap triangle sampler: banked height grid with a pipelined interpolation datapath.
//
// Usage: each request arrives on the s_ stream. s_tuser selects the kind: a write stores
// height_in at the integer grid point of (pos_x, pos_z) and yields no result; a query
// returns one interpolated height on the m_ stream. Positions are unsigned fixed point
// with FRAC_BITS fraction bits; integer parts beyond the grid saturate at the last point.
// The grid lives in four memories banked by the parities of x and z, so the four
// corners of a cell are always read in the same cycle, one per bank.
// A query passes four register stages: the bank read at its accepting edge, the triangle
// select with corner differences, the two weight multiplies, and the final sum into the
// output register. One request is accepted every cycle while s_tready is high, writes
// and queries mixed freely; a write is visible to every query accepted after it.
// When the receiver stalls, each stage holds only while the stage after it is full, so
// empty slots close up and s_tready stays high until the whole pipeline is occupied.
// Reset clears the pipeline valid bits; the grid itself is not cleared, and a query that
// touches a point never written returns an undefined value.
module heightmap_triangle_sample #(
    parameter int GRID_DIM    = hts_pkg::GRID_DIM_DEF,
    parameter int FRAC_BITS   = hts_pkg::FRAC_BITS_DEF,
    parameter int HEIGHT_BITS = hts_pkg::HEIGHT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Request channel.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // pos_x [15:0], pos_z [31:16], height_in [47:32]
    input  logic [hts_pkg::S_DATA_W-1:0] s_tdata,
    // action [0]
    input  logic                         s_tuser,
    // Result channel.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // height_out [23:0]
    output logic [hts_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int F      = FRAC_BITS;
    localparam int H      = HEIGHT_BITS;
    localparam int XW     = $clog2(GRID_DIM);
    localparam int HALF   = (GRID_DIM + 1) / 2;
    localparam int DEPTH_B = HALF * HALF;
    localparam int BAW    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
    localparam int PW     = H + F + 2;
    localparam int RW     = H + F + 3;
    localparam logic [XW-1:0] LAST_IDX = XW'(GRID_DIM - 1);
    localparam logic [F:0]    ONE_FX   = {1'b1, {F{1'b0}}};

    // Input field unpacking.
    logic [hts_pkg::POS_W-1:0] pos_x;
    logic [hts_pkg::POS_W-1:0] pos_z;
    logic [hts_pkg::HIN_W-1:0] height_in;
    assign pos_x     = s_tdata[15:0];
    assign pos_z     = s_tdata[31:16];
    assign height_in = s_tdata[47:32];

    // Pipeline handshake: a stage advances when the next one is empty or advancing.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, m_valid_next;
    logic en1, en2, en3, en4;
    logic accept, query_acc, write_acc;

    assign en4 = !m_valid_reg || m_tready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign s_tready  = en1;
    assign accept    = s_tvalid && en1;
    assign query_acc = accept && (s_tuser == hts_pkg::ACT_QUERY);
    assign write_acc = accept && (s_tuser == hts_pkg::ACT_WRITE);

    // Grid coordinates with saturation at the far edge.
    logic [31:0]   ix_full, iz_full;
    logic [XW-1:0] x0, z0, x1, z1;
    logic          x_last, z_last;

    assign ix_full = 32'(pos_x) >> F;
    assign iz_full = 32'(pos_z) >> F;
    assign x0      = (ix_full > 32'(GRID_DIM - 1)) ? LAST_IDX : ix_full[XW-1:0];
    assign z0      = (iz_full > 32'(GRID_DIM - 1)) ? LAST_IDX : iz_full[XW-1:0];
    assign x_last  = (x0 == LAST_IDX);
    assign z_last  = (z0 == LAST_IDX);
    assign x1      = x_last ? x0 : x0 + XW'(1);
    assign z1      = z_last ? z0 : z0 + XW'(1);

    // Height written to the grid: sign-extended from the port, then wrapped to H bits.
    logic signed [31:0] hin_ext;
    logic [H-1:0]       wr_height;
    logic [BAW-1:0]     wr_addr;

    assign hin_ext   = 32'(signed'(height_in));
    assign wr_height = hin_ext[H-1:0];
    assign wr_addr   = BAW'((32'(x0) >> 1) * HALF + (32'(z0) >> 1));

    logic [H-1:0] bank_q [hts_pkg::NUM_BANKS];

    // Bank {px, pz} holds points whose x parity is px and z parity is pz. Each query
    // reads, in every bank, the one corner of the 2x2 neighborhood with that parity.
    for (genvar b = 0; b < hts_pkg::NUM_BANKS; b++) begin : g_bank
        localparam logic PX = 1'((b / 2) % 2);
        localparam logic PZ = 1'(b % 2);

        logic [H-1:0]   mem [0:DEPTH_B-1];
        logic [H-1:0]   rd_q_reg;
        logic [XW-1:0]  xb, zb;
        logic [BAW-1:0] rd_addr;
        logic           wr_en;

        assign xb      = (x0[0] == PX) ? x0 : x1;
        assign zb      = (z0[0] == PZ) ? z0 : z1;
        assign rd_addr = BAW'((32'(xb) >> 1) * HALF + (32'(zb) >> 1));
        assign wr_en   = write_acc && (x0[0] == PX) && (z0[0] == PZ);

        always_ff @(posedge aclk) begin
            if (wr_en) begin
                mem[wr_addr] <= wr_height;
            end
            if (query_acc) begin
                rd_q_reg <= mem[rd_addr];
            end
        end

        assign bank_q[b] = rd_q_reg;
    end

    // Stage 1: fractions, corner parities and far-edge flags captured alongside the bank reads.
    logic [F-1:0] s1_fx_reg, s1_fz_reg;
    logic         s1_xp_reg, s1_zp_reg, s1_xl_reg, s1_zl_reg;

    always_ff @(posedge aclk) begin
        if (query_acc) begin
            s1_fx_reg <= pos_x[F-1:0];
            s1_fz_reg <= pos_z[F-1:0];
            s1_xp_reg <= x0[0];
            s1_zp_reg <= z0[0];
            s1_xl_reg <= x_last;
            s1_zl_reg <= z_last;
        end
    end

    // Map logical corners to banks; at the far edge the neighbor folds onto the base.
    logic              xp1, zp1;
    logic signed [H-1:0] h00, h10, h01, h11;
    logic [F:0]        fsum;
    logic              upper;
    logic signed [H-1:0] base_c;
    logic [F:0]        wa_c, wb_c;
    logic signed [H:0] da_c, db_c;

    assign xp1 = s1_xl_reg ? s1_xp_reg : !s1_xp_reg;
    assign zp1 = s1_zl_reg ? s1_zp_reg : !s1_zp_reg;
    assign h00 = bank_q[{s1_xp_reg, s1_zp_reg}];
    assign h10 = bank_q[{xp1, s1_zp_reg}];
    assign h01 = bank_q[{s1_xp_reg, zp1}];
    assign h11 = bank_q[{xp1, zp1}];

    // Points exactly on the diagonal take the lower triangle.
    assign fsum  = {1'b0, s1_fx_reg} + {1'b0, s1_fz_reg};
    assign upper = (fsum > ONE_FX);

    always_comb begin
        if (upper) begin
            base_c = h11;
            wa_c   = ONE_FX - {1'b0, s1_fx_reg};
            da_c   = {h01[H-1], h01} - {h11[H-1], h11};
            wb_c   = ONE_FX - {1'b0, s1_fz_reg};
            db_c   = {h10[H-1], h10} - {h11[H-1], h11};
        end else begin
            base_c = h00;
            wa_c   = {1'b0, s1_fx_reg};
            da_c   = {h10[H-1], h10} - {h00[H-1], h00};
            wb_c   = {1'b0, s1_fz_reg};
            db_c   = {h01[H-1], h01} - {h00[H-1], h00};
        end
    end

    // Stage 2: base height, weights and edge differences.
    logic signed [H-1:0] s2_base_reg;
    logic [F:0]          s2_wa_reg, s2_wb_reg;
    logic signed [H:0]   s2_da_reg, s2_db_reg;

    always_ff @(posedge aclk) begin
        if (en2 && s1_valid_reg) begin
            s2_base_reg <= base_c;
            s2_wa_reg   <= wa_c;
            s2_da_reg   <= da_c;
            s2_wb_reg   <= wb_c;
            s2_db_reg   <= db_c;
        end
    end

    // Stage 3: the two weighted edge terms.
    logic signed [H-1:0]  s3_base_reg;
    logic signed [PW-1:0] s3_pa_reg, s3_pb_reg;

    always_ff @(posedge aclk) begin
        if (en3 && s2_valid_reg) begin
            s3_base_reg <= s2_base_reg;
            s3_pa_reg   <= PW'($signed({1'b0, s2_wa_reg})) * PW'(s2_da_reg);
            s3_pb_reg   <= PW'($signed({1'b0, s2_wb_reg})) * PW'(s2_db_reg);
        end
    end

    // Output: base scaled to fixed point plus both terms, reduced to the 24-bit field.
    logic signed [RW-1:0] base_ext, r_sum;
    logic signed [63:0]   r_wide;
    logic [hts_pkg::HOUT_W-1:0] m_data_reg;

    assign base_ext = RW'(s3_base_reg);
    assign r_sum    = (base_ext <<< F) + RW'(s3_pa_reg) + RW'(s3_pb_reg);
    assign r_wide   = 64'(r_sum);

    always_ff @(posedge aclk) begin
        if (en4 && s3_valid_reg) begin
            m_data_reg <= r_wide[hts_pkg::HOUT_W-1:0];
        end
    end

    // Valid bits.
    assign s1_valid_next = en1 ? (s_tvalid && (s_tuser == hts_pkg::ACT_QUERY)) : s1_valid_reg;
    assign s2_valid_next = en2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = en3 ? s2_valid_reg : s3_valid_reg;
    assign m_valid_next  = en4 ? s3_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
